FILE: src/mwg_pkg.sv
// Shared types, constants and the sine table of the multi-waveform sample generator.
// Used by mwg_div, mwg_ctrl, mwg_datapath and the top level; depends on nothing else.
`default_nettype none
package mwg_pkg;

  // Register widths
  localparam int RATE_W  = 20;
  localparam int FREQ_W  = 15;
  localparam int LEVEL_W = 8;
  localparam int PHASE_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQUENCY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL      = 3'd4;

  localparam logic [RATE_W-1:0]  RATE_RST  = 20'd44100;
  localparam logic [FREQ_W-1:0]  FREQ_RST  = 15'd60;
  localparam logic [LEVEL_W-1:0] MIN_RST   = 8'd0;
  localparam logic [LEVEL_W-1:0] MAX_RST   = 8'd255;

  // Stream widths
  localparam int COUNT_W      = 7;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 16;
  localparam int MAX_SAMPLES  = 64;

  // Sine table
  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam int SINE_W     = 16;

  // Divider sizing: triangle quotient needs LEVEL_W+1 bits, sine index SINE_IDX_W bits
  localparam int SAMPLE_QW  = (SINE_IDX_W > LEVEL_W + 1) ? SINE_IDX_W : LEVEL_W + 1;
  localparam int TRI_NUM_W  = LEVEL_W + PHASE_W + 3;
  localparam int SINE_NUM_W = PHASE_W + SINE_IDX_W;
  localparam int DIV_NUM_W  = (TRI_NUM_W > SINE_NUM_W) ? TRI_NUM_W : SINE_NUM_W;
  localparam int DIV_DEN_W  = PHASE_W + 1;
  localparam int DIV_Q_W    = (RATE_W > SAMPLE_QW) ? RATE_W : SAMPLE_QW;
  localparam int DIV_SH_W   = DIV_DEN_W + DIV_Q_W - 1;
  localparam int DIV_CNT_W  = $clog2(DIV_Q_W);
  localparam int PERIOD_TOP = RATE_W - 1;
  localparam int SAMPLE_TOP = SAMPLE_QW - 1;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SAWTOOTH = 2'd3
  } shape_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic period_start;
    logic period_load;
    logic wrap;
    logic mul;
    logic div_start;
    logic level_calc;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_empty;
    logic div_done;
    logic out_free;
    logic last_sample;
  } ctrl_sts_t;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_DEPTH];

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // shift-and-subtract long division for the series terms
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // (sin + 1) / 2 in Q0.16 from an integer Taylor series, evaluated at elaboration
  function automatic logic [SINE_W-1:0] sine_entry(input longint unsigned i);
    longint unsigned q4, quad, rem, x, term, d, y;
    longint sum;
    logic cos_f;
    q4    = 4 * i;
    quad  = q4 / SINE_DEPTH;
    rem   = q4 - quad * SINE_DEPTH;
    x     = HALF_PI_Q30 * rem / SINE_DEPTH;
    cos_f = quad[0];
    term  = cos_f ? ONE_Q30 : x;
    sum   = longint'(term);
    for (int k = 0; k < 7; k++) begin
      d = cos_f ? longint'((2 * k + 1) * (2 * k + 2)) : longint'((2 * k + 2) * (2 * k + 3));
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = udiv64(term, d);
      if ((k % 2) == 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (quad >= 2) begin
      sum = -sum;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    if (sum < -longint'(ONE_Q30)) begin
      sum = -longint'(ONE_Q30);
    end
    y = (longint'(sum + longint'(ONE_Q30)) + 64'd16384) >> 15;
    if (y > 64'd65535) begin
      y = 64'd65535;
    end
    return y[SINE_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      tab[i] = sine_entry(longint'(i));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

FILE: src/mwg_div.sv
// Restoring divider, one quotient bit per cycle, shared by the period and level divisions.
// Depends on mwg_pkg for its widths.
`default_nettype none
module mwg_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           wide,   // period division: more quotient bits
  input  wire logic [mwg_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [mwg_pkg::DIV_DEN_W-1:0]  den,
  output logic                                done,
  output logic [mwg_pkg::DIV_Q_W-1:0]         quo
);

  logic [mwg_pkg::DIV_NUM_W-1:0] rem_r;
  logic [mwg_pkg::DIV_SH_W-1:0]  dsh_r;
  logic [mwg_pkg::DIV_Q_W-1:0]   q_r;
  logic [mwg_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic                          ge;

  assign ge = mwg_pkg::DIV_SH_W'(rem_r) >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= wide ? mwg_pkg::DIV_CNT_W'(mwg_pkg::PERIOD_TOP)
                       : mwg_pkg::DIV_CNT_W'(mwg_pkg::SAMPLE_TOP);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // numerator is known to be below den << (top + 1), so top + 1 quotient bits suffice
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      q_r   <= '0;
      dsh_r <= wide ? (mwg_pkg::DIV_SH_W'(den) << mwg_pkg::PERIOD_TOP)
                    : (mwg_pkg::DIV_SH_W'(den) << mwg_pkg::SAMPLE_TOP);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r[mwg_pkg::DIV_NUM_W-1:0];
      end
      q_r   <= {q_r[mwg_pkg::DIV_Q_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

FILE: src/mwg_ctrl.sv
// Sample generator sequencer: period division per non-empty request, then per-sample steps.
// Depends on mwg_pkg for the command and status structs.
`default_nettype none
module mwg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire mwg_pkg::ctrl_sts_t sts,
  output mwg_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PDIV   = 8'b0000_0010,
    S_WRAP   = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_DSTART = 8'b0001_0000,
    S_DWAIT  = 8'b0010_0000,
    S_LEVEL  = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (!sts.req_empty) begin
            cmd.period_start = 1'b1;
            state_nxt        = S_PDIV;
          end
        end
      end
      S_PDIV: begin
        if (sts.div_done) begin
          cmd.period_load = 1'b1;
          state_nxt       = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.level_calc = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_sample ? S_IDLE : S_WRAP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule
`default_nettype wire

FILE: src/mwg_datapath.sv
// Datapath: configuration registers, period and phase, level arithmetic, output register.
// Depends on mwg_pkg and instantiates mwg_div.
`default_nettype none
module mwg_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mwg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mwg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [mwg_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire mwg_pkg::ctrl_cmd_t               cmd,
  output mwg_pkg::ctrl_sts_t                    sts,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [mwg_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast
);

  localparam int LW   = mwg_pkg::LEVEL_W;
  localparam int PW   = mwg_pkg::PHASE_W;
  localparam int LVW  = LW + 2;
  localparam int SPW  = LW + mwg_pkg::SINE_W + 1;

  logic [mwg_pkg::RATE_W-1:0]  rate_r;
  logic [mwg_pkg::FREQ_W-1:0]  freq_r;
  mwg_pkg::shape_t             shape_r;
  logic [LW-1:0]               min_r, max_r;

  logic [mwg_pkg::COUNT_W-1:0] count_r, req_cnt;
  logic [PW-1:0]               phase_r, period_r, half;
  logic [LW+PW-1:0]            prod_r;
  logic [LW-1:0]               range, level_r, level_nxt;
  logic                        out_tvalid_r, out_tlast_r;
  logic [mwg_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic                            div_start, div_done;
  logic [mwg_pkg::DIV_NUM_W-1:0]   div_num, sample_num;
  logic [mwg_pkg::DIV_DEN_W-1:0]   div_den;
  logic [mwg_pkg::DIV_Q_W-1:0]     quo;
  logic [mwg_pkg::FREQ_W-1:0]      freq_nz;

  logic [mwg_pkg::SINE_W-1:0]  sine_t;
  logic [SPW-1:0]              sine_rnd;
  logic [LVW-1:0]              lvl, qv, m_x, r_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= mwg_pkg::RATE_RST;
      freq_r  <= mwg_pkg::FREQ_RST;
      shape_r <= mwg_pkg::SHAPE_SINE;
      min_r   <= mwg_pkg::MIN_RST;
      max_r   <= mwg_pkg::MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwg_pkg::REG_SAMPLE_RATE:    rate_r  <= cfg_wdata[mwg_pkg::RATE_W-1:0];
        mwg_pkg::REG_TONE_FREQUENCY: freq_r  <= cfg_wdata[mwg_pkg::FREQ_W-1:0];
        mwg_pkg::REG_WAVE_SHAPE:     shape_r <= mwg_pkg::shape_t'(cfg_wdata[1:0]);
        mwg_pkg::REG_MIN_LEVEL:      min_r   <= cfg_wdata[LW-1:0];
        mwg_pkg::REG_MAX_LEVEL:      max_r   <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // inverted levels collapse to a flat output at min
  assign range   = (max_r >= min_r) ? (max_r - min_r) : '0;
  assign freq_nz = (freq_r == '0) ? mwg_pkg::FREQ_W'(1) : freq_r;
  assign req_cnt = in_tdata[mwg_pkg::COUNT_W-1:0];
  assign half    = period_r >> 1;

  // Divider operands: sine index p*DEPTH/P, ramps use round-half-up (2N+D)/(2D)
  always_comb begin
    unique case (shape_r)
      mwg_pkg::SHAPE_SINE:
        sample_num = mwg_pkg::DIV_NUM_W'({phase_r, mwg_pkg::SINE_IDX_W'(0)});
      mwg_pkg::SHAPE_TRIANGLE:
        sample_num = mwg_pkg::DIV_NUM_W'({prod_r, 2'b00}) + mwg_pkg::DIV_NUM_W'(period_r);
      mwg_pkg::SHAPE_SQUARE,
      mwg_pkg::SHAPE_SAWTOOTH:
        sample_num = mwg_pkg::DIV_NUM_W'({prod_r, 1'b0}) + mwg_pkg::DIV_NUM_W'(period_r);
    endcase
  end

  assign div_start = cmd.period_start | cmd.div_start;
  assign div_num   = cmd.period_start ? mwg_pkg::DIV_NUM_W'(rate_r) : sample_num;
  assign div_den   = cmd.period_start ? mwg_pkg::DIV_DEN_W'(freq_nz)
                   : (shape_r == mwg_pkg::SHAPE_SINE) ? mwg_pkg::DIV_DEN_W'(period_r)
                   : {period_r, 1'b0};

  mwg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .wide  (cmd.period_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // Level from the quotient; sums kept two bits wide of the level, low byte taken
  assign sine_t   = mwg_pkg::SINE_TAB[quo[mwg_pkg::SINE_IDX_W-1:0]];
  assign sine_rnd = SPW'(range * sine_t) + SPW'(32768);
  assign qv       = LVW'(quo[mwg_pkg::SAMPLE_QW-1:0]);
  assign m_x      = LVW'(min_r);
  assign r_x      = LVW'(range);

  always_comb begin
    unique case (shape_r)
      mwg_pkg::SHAPE_SINE:
        lvl = m_x + LVW'(sine_rnd[SPW-1:mwg_pkg::SINE_W]);
      mwg_pkg::SHAPE_SQUARE: begin
        if (phase_r < half) begin
          lvl = m_x + r_x;
        end else if (phase_r > half) begin
          lvl = m_x;
        end else begin
          lvl = m_x + (r_x >> 1);
        end
      end
      mwg_pkg::SHAPE_TRIANGLE: begin
        if (phase_r < half) begin
          lvl = m_x + qv;
        end else begin
          lvl = m_x + (r_x << 1) - qv;
        end
      end
      mwg_pkg::SHAPE_SAWTOOTH:
        lvl = m_x + qv;
    endcase
  end

  assign level_nxt = lvl[LW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= '0;
    end else begin
      if (cmd.accept) begin
        count_r <= (req_cnt > mwg_pkg::COUNT_W'(mwg_pkg::MAX_SAMPLES))
                 ? mwg_pkg::COUNT_W'(mwg_pkg::MAX_SAMPLES) : req_cnt;
      end else if (cmd.emit) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.wrap && (phase_r >= period_r)) begin
        phase_r <= '0;
      end else if (cmd.emit) begin
        phase_r <= phase_r + 1'b1;
      end
    end
  end

  // period clamped to [1, 2^PHASE_W - 1]
  always_ff @(posedge clk) begin
    if (cmd.period_load) begin
      if (quo == '0) begin
        period_r <= PW'(1);
      end else if (quo[mwg_pkg::DIV_Q_W-1:PW] != '0) begin
        period_r <= '1;
      end else begin
        period_r <= quo[PW-1:0];
      end
    end
    if (cmd.mul) begin
      prod_r <= range * phase_r;
    end
    if (cmd.level_calc) begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {level_r, LW'(0)};
      out_tlast_r <= (count_r == mwg_pkg::COUNT_W'(1));
    end
  end

  assign sts.req_empty   = (req_cnt == '0);
  assign sts.div_done    = div_done;
  assign sts.out_free    = !out_tvalid_r || out_tready;
  assign sts.last_sample = (count_r == mwg_pkg::COUNT_W'(1));

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_wrap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wrap |=> (phase_r < period_r))
    else $error("phase not below period after wrap");

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.period_load |=> (period_r != '0))
    else $error("period loaded as zero");

  a_sample_quo_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.level_calc |-> (quo[mwg_pkg::DIV_Q_W-1:mwg_pkg::SAMPLE_QW] == '0))
    else $error("level quotient overflow");

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid_r || out_tready))
    else $error("item overwritten in output register");

endmodule
`default_nettype wire

FILE: src/multi_waveform_sample_generator.sv
// Top level of the multi-waveform sample generator: controller plus datapath.
// Depends on mwg_pkg, mwg_ctrl, mwg_datapath (and through it mwg_div).
//
// Each input item asks for sample_count (1..64, larger values saturate to 64, zero gives
// nothing) consecutive DAC samples of a sine, square, triangle or sawtooth wave between
// min_level and max_level, one output item per sample with the level in the upper byte and
// tlast on the final one. The phase counter carries over between requests. A non-empty
// request first passes the accepting step and the 20-step division of sample_rate by
// tone_frequency into the period; every sample then passes the wrap, multiply and start
// steps, the one-bit-per-cycle divider that scales the phase (9 steps and a done strobe),
// then the level and output steps, the output step waiting while the output is held back.
// One request is worked on at a time. Configuration is written through cfg_we/cfg_index/
// cfg_wdata; the user must write only while the block is idle, unchecked by the block.
`default_nettype none
module multi_waveform_sample_generator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mwg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mwg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mwg_pkg::IN_TDATA_W-1:0]   in_tdata,   // [6:0] sample_count, [7] zero
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [mwg_pkg::OUT_TDATA_W-1:0]       out_tdata,  // [15:0] dac_word
  output logic                                  out_tlast
);

  mwg_pkg::ctrl_cmd_t cmd;
  mwg_pkg::ctrl_sts_t sts;

  mwg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mwg_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: tb/multi_waveform_sample_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_waveform_sample_generator: sample-run requests in,
// DAC sample stream out, checked against an in-bench waveform predictor.
// Depends on mwg_pkg (port widths, register indexes, shape codes) and the RTL top level.
module multi_waveform_sample_generator_tb;

  localparam int TABLE_DEPTH = 256;
  localparam int RUN_MAX     = 64;
  localparam int SETTLE      = 100;

  typedef logic [mwg_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [mwg_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct {
    logic [mwg_pkg::OUT_TDATA_W-1:0] dac_word;
    logic                            last;
  } sample_t;

  class sample_scoreboard;
    logic [mwg_pkg::RATE_W-1:0]  rate;
    logic [mwg_pkg::FREQ_W-1:0]  freq;
    mwg_pkg::shape_t             shape;
    logic [mwg_pkg::LEVEL_W-1:0] min_lvl;
    logic [mwg_pkg::LEVEL_W-1:0] max_lvl;
    logic [mwg_pkg::PHASE_W-1:0] phase;
    logic [15:0]                 half_sine [TABLE_DEPTH];
    sample_t                     pending_samples [$];
    int                          errors;

    function new();
      rate    = 20'd44100;
      freq    = 15'd60;
      shape   = mwg_pkg::SHAPE_SINE;
      min_lvl = 8'd0;
      max_lvl = 8'd255;
      phase   = '0;
      errors  = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        half_sine[i] = sine_point(i);
      end
    endfunction

    // (sin + 1) / 2 in Q0.16, quadrant-folded Taylor series in Q2.30
    function automatic logic [15:0] sine_point(input int i);
      longint unsigned quad, rem, x, term, d, y;
      longint acc;
      bit use_cos;
      quad    = longint'(4 * i) / TABLE_DEPTH;
      rem     = longint'(4 * i) - quad * TABLE_DEPTH;
      x       = 64'd1686629713 * rem / TABLE_DEPTH;
      use_cos = quad[0];
      term    = use_cos ? (64'd1 << 30) : x;
      acc     = longint'(term);
      for (int k = 0; k < 7; k++) begin
        d    = use_cos ? longint'((2 * k + 1) * (2 * k + 2)) : longint'((2 * k + 2) * (2 * k + 3));
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / d;
        if (k % 2 == 0) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (quad >= 2) begin
        acc = -acc;
      end
      if (acc > longint'(64'd1 << 30)) acc = longint'(64'd1 << 30);
      if (acc < -longint'(64'd1 << 30)) acc = -longint'(64'd1 << 30);
      y = (unsigned'(acc + longint'(64'd1 << 30)) + 64'd16384) >> 15;
      if (y > 64'd65535) y = 64'd65535;
      return y[15:0];
    endfunction

    function automatic longint unsigned round_half_up(input longint unsigned num,
                                                      input longint unsigned den);
      return (2 * num + den) / (2 * den);
    endfunction

    function void write_reg(input cfg_idx_t idx, input cfg_word_t val);
      case (idx)
        mwg_pkg::REG_SAMPLE_RATE:    rate    = val[mwg_pkg::RATE_W-1:0];
        mwg_pkg::REG_TONE_FREQUENCY: freq    = val[mwg_pkg::FREQ_W-1:0];
        mwg_pkg::REG_WAVE_SHAPE:     shape   = mwg_pkg::shape_t'(val[1:0]);
        mwg_pkg::REG_MIN_LEVEL:      min_lvl = val[mwg_pkg::LEVEL_W-1:0];
        mwg_pkg::REG_MAX_LEVEL:      max_lvl = val[mwg_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the sample run caused by one accepted request
    function void note_request(input logic [mwg_pkg::COUNT_W-1:0] count);
      longint unsigned per, rng, m, p, lvl, a, half, idx;
      int n;
      sample_t s;
      n   = (count > RUN_MAX) ? RUN_MAX : int'(count);
      per = longint'(rate) / ((freq == 0) ? 64'd1 : longint'(freq));
      if (per < 1) per = 1;
      if (per > 65535) per = 65535;
      rng  = (max_lvl >= min_lvl) ? longint'(max_lvl - min_lvl) : 64'd0;
      m    = min_lvl;
      half = per / 2;
      for (int k = 0; k < n; k++) begin
        if (phase >= per) phase = '0;
        p = phase;
        case (shape)
          mwg_pkg::SHAPE_SINE: begin
            idx = p * TABLE_DEPTH / per;
            if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
            lvl = m + ((rng * half_sine[idx] + 64'd32768) >> 16);
          end
          mwg_pkg::SHAPE_SQUARE: begin
            if (p < half) lvl = m + rng;
            else if (p > half) lvl = m;
            else lvl = m + rng / 2;
          end
          mwg_pkg::SHAPE_TRIANGLE: begin
            a   = round_half_up(2 * rng * p, per);
            lvl = (p < half) ? m + a : m + 2 * rng - a;
          end
          default: lvl = m + round_half_up(rng * p, per);
        endcase
        // only the low byte of the level survives the shift into the word
        s.dac_word = {lvl[7:0], 8'h00};
        s.last     = (k == n - 1);
        pending_samples.push_back(s);
        phase = phase + 1'b1;
      end
    endfunction

    function void check_sample(input logic [mwg_pkg::OUT_TDATA_W-1:0] word, input logic last);
      sample_t e;
      if (pending_samples.size() == 0) begin
        $error("unexpected sample: dac_word %h last %b", word, last);
        errors++;
        return;
      end
      e = pending_samples.pop_front();
      if (word !== e.dac_word) begin
        $error("dac_word: expected %h, got %h", e.dac_word, word);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %b, got %b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  cfg_idx_t                        cfg_index  = '0;
  cfg_word_t                       cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [mwg_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;   // [6:0] sample_count, [7] zero
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mwg_pkg::OUT_TDATA_W-1:0] out_tdata;         // [15:0] dac_word
  logic                            out_tlast;

  sample_scoreboard sb;
  bit idling = 1'b1;

  multi_waveform_sample_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sample(out_tdata, out_tlast);
  end

  // Output back-pressure in random bursts
  initial begin : sink_stall
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0 && idling && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 19);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with in_tvalid still high
  task automatic send_request(input int unsigned count);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, count[mwg_pkg::COUNT_W-1:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(count[mwg_pkg::COUNT_W-1:0]);
    @(negedge clk);
  endtask

  // Waits until every predicted sample has been checked, then for the settle time
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input cfg_word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_word_t rate_raw, freq_raw, shape_raw, min_raw,
                                max_raw, input bit stray);
    cfg_write(mwg_pkg::REG_SAMPLE_RATE, rate_raw);
    cfg_write(mwg_pkg::REG_TONE_FREQUENCY, freq_raw);
    cfg_write(mwg_pkg::REG_WAVE_SHAPE, shape_raw);
    cfg_write(mwg_pkg::REG_MIN_LEVEL, min_raw);
    cfg_write(mwg_pkg::REG_MAX_LEVEL, max_raw);
    if (stray) begin
      cfg_write(cfg_idx_t'($urandom_range(int'(mwg_pkg::REG_MAX_LEVEL) + 1,
                                          (1 << mwg_pkg::CFG_IDX_W) - 1)),
                cfg_word_t'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings();
    cfg_word_t r, f, s, mn, mx;
    case ($urandom_range(0, 5))
      0: begin  // short periods, plenty of wraps
        r = cfg_word_t'($urandom_range(1, 400));
        f = cfg_word_t'($urandom_range(1, 4));
      end
      1: begin
        r = 20'd44100;
        f = cfg_word_t'($urandom_range(20, 2000));
      end
      2: begin
        r = cfg_word_t'($urandom_range(1, 1000000));
        f = cfg_word_t'($urandom_range(1, 20000));
      end
      3: begin  // period often clamps at the top
        r = $urandom_range(0, 1) ? 20'hFFFFF : 20'd1000000;
        f = $urandom_range(0, 1) ? 20'd1 : cfg_word_t'($urandom_range(1, 20));
      end
      4: begin  // period below one, or zero frequency
        r = cfg_word_t'($urandom_range(0, 100));
        f = cfg_word_t'($urandom_range(0, 200));
      end
      default: begin
        r = cfg_word_t'($urandom) & 20'hFFFFF;
        f = cfg_word_t'($urandom) & 20'h07FFF;
      end
    endcase
    case ($urandom_range(0, 3))
      0: begin
        mn = 20'd0;
        mx = 20'd255;
      end
      1: begin
        mn = cfg_word_t'($urandom_range(0, 255));
        mx = cfg_word_t'($urandom_range(int'(mn), 255));
      end
      2: begin  // may come out inverted
        mn = cfg_word_t'($urandom_range(0, 255));
        mx = cfg_word_t'($urandom_range(0, 255));
      end
      default: begin
        mn = cfg_word_t'($urandom_range(0, 255));
        mx = mn;
      end
    endcase
    s = cfg_word_t'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      // junk above each register's width
      f  = f  | (cfg_word_t'($urandom) & 20'hF8000);
      s  = s  | (cfg_word_t'($urandom) & 20'hFFFFC);
      mn = mn | (cfg_word_t'($urandom) & 20'hFFF00);
      mx = mx | (cfg_word_t'($urandom) & 20'hFFF00);
    end
    apply_settings(r, f, s, mn, mx, $urandom_range(0, 3) == 0);
  endtask

  function automatic int unsigned random_count();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(RUN_MAX + 1, 127);
      2:       return RUN_MAX;
      3:       return 1;
      default: return $urandom_range(1, RUN_MAX);
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: sine over the full range, period 735
    send_request(1);
    send_request(RUN_MAX);
    send_request(0);
    send_request(127);
    wait_idle();

    // Square, even period: hits the exact midpoint
    apply_settings(20'd20, 20'd1, cfg_word_t'(mwg_pkg::SHAPE_SQUARE), 20'd10, 20'd200, 1'b0);
    send_request(RUN_MAX);
    send_request(41);
    wait_idle();

    // Triangle, odd period
    apply_settings(20'd7, 20'd1, cfg_word_t'(mwg_pkg::SHAPE_TRIANGLE), 20'd0, 20'd255, 1'b0);
    send_request(RUN_MAX);
    wait_idle();

    // Sawtooth, zero frequency and clamped period, values wider than the registers
    apply_settings(20'hFFFFF, 20'h80000, 20'hFFFF7, 20'hFFF00, 20'h3FFFF, 1'b0);
    send_request(RUN_MAX);
    send_request(100);
    wait_idle();

    // Period below one, inverted levels, stray register index
    apply_settings(20'd5, 20'd20000, cfg_word_t'(mwg_pkg::SHAPE_TRIANGLE), 20'd255, 20'd0,
                   1'b1);
    send_request(3);
    send_request(10);
    wait_idle();

    // Phase left beyond a shorter period
    apply_settings(20'd100, 20'd1, cfg_word_t'(mwg_pkg::SHAPE_SINE), 20'd0, 20'd255, 1'b0);
    send_request(RUN_MAX);
    send_request(20);
    wait_idle();
    apply_settings(20'd30, 20'd1, cfg_word_t'(mwg_pkg::SHAPE_SINE), 20'd128, 20'd128, 1'b0);
    send_request(5);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      random_settings();
      if (ph >= 8) idling = 1'b0;
      for (int i = 0; i < 25; i++) begin
        send_request(random_count());
      end
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
src/mwg_pkg.sv
src/mwg_div.sv
src/mwg_ctrl.sv
src/mwg_datapath.sv
src/multi_waveform_sample_generator.sv
tb/multi_waveform_sample_generator_tb.sv
